/* sv/kuz_pkg.sv */
package kuz_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   sbox_t [256];
  typedef blk_t         lmat_t [128];
  typedef blk_t         ctab_t [32];

  localparam int unsigned NumRoundKeys  = 10;
  localparam int unsigned ScheduleSteps = 32;
  localparam logic [8:0]  GfPoly        = 9'h1C3;

  // datapath commands from the controller
  typedef struct packed {
    logic       load;
    logic       key_start;
    logic       key_step;
    logic       round_step;
    logic       round_last;
    logic [4:0] cnt;
  } kuz_cmd_t;

  localparam sbox_t SBOX = '{
    8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
    8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
    8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
    8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
    8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
    8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
    8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
    8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
    8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
    8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
    8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
    8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
    8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
    8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
    8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
    8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
    8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
    8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
    8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
    8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
    8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
    8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
    8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
    8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
    8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
    8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
    8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
    8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
    8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
    8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
    8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
    8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
  };

  localparam logic [7:0] LIN_COEF [16] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ GfPoly;
    end
    return r;
  endfunction

  // elaboration-time reference forms of the linear layer
  function automatic blk_t lin_l_ref(input blk_t s_in);
    blk_t s;
    logic [7:0] acc;
    s = s_in;
    for (int n = 0; n < 16; n++) begin
      acc = '0;
      for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(LIN_COEF[i], s[127-8*i -: 8]);
      s = {acc, s[127:8]};
    end
    return s;
  endfunction

  function automatic blk_t lin_inv_ref(input blk_t s_in);
    blk_t s;
    logic [7:0] x;
    s = s_in;
    for (int n = 0; n < 16; n++) begin
      x = s[127:120];
      for (int i = 0; i < 15; i++) x = x ^ gf_mul(LIN_COEF[i], s[119-8*i -: 8]);
      s = {s[119:0], x};
    end
    return s;
  endfunction

  function automatic lmat_t build_lin(input logic inv);
    lmat_t m;
    for (int k = 0; k < 128; k++) begin
      m[k] = inv ? lin_inv_ref(blk_t'(1) << k) : lin_l_ref(blk_t'(1) << k);
    end
    return m;
  endfunction

  function automatic sbox_t build_sbox_inv();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[SBOX[i]] = 8'(i);
    return t;
  endfunction

  function automatic ctab_t build_consts();
    ctab_t c;
    for (int i = 0; i < 32; i++) c[i] = lin_l_ref(blk_t'(i + 1));
    return c;
  endfunction

  localparam lmat_t L_MAT    = build_lin(1'b0);
  localparam lmat_t LINV_MAT = build_lin(1'b1);
  localparam sbox_t SBOX_INV = build_sbox_inv();
  localparam ctab_t KEY_CONST = build_consts();

  // linear layer as a constant GF(2) matrix: one column per input bit
  function automatic blk_t lin_apply(input blk_t s, input lmat_t m);
    blk_t r;
    r = '0;
    for (int k = 0; k < 128; k++) begin
      if (s[k]) r = r ^ m[k];
    end
    return r;
  endfunction

  function automatic blk_t sub_bytes(input blk_t s, input sbox_t t);
    blk_t r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = t[s[8*i +: 8]];
    return r;
  endfunction

endpackage

/* sv/block_cipher_128_gost.sv */
// channel   | ports                                        | transfer
// ----------+----------------------------------------------+------------------------------
// block in  | start, busy, command_i, block_high_i/_low_i  | edge with start high, busy low
// result    | out_valid_o, out_high_o, out_low_o           | the one cycle out_valid_o is high
// config    | psel, penable, pwrite, paddr, pwdata, prdata | psel & penable & pwrite & pready
//
// a block passes from transfer to result strobe through the iterative round core, which
// does one round per cycle; the next block may transfer while the strobe is up
// a key write marks the round keys stale; the 32-step key schedule then runs one step
// per cycle with busy high, and runs again after it ends if the key is written again
// after reset the all-zero key is expanded the same way, so busy stays high until then
// the receiver cannot stall: each result shows for exactly one cycle
module block_cipher_128_gost (
  input  logic        clk_i,
  input  logic        rst_ni,
  // block channel
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  // result channel
  output logic        out_valid_o,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  // key registers, 64 bits each at byte address 8*i
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  kuz_pkg::kuz_cmd_t cmd;
  logic [255:0]      key;
  logic              stale;

  // key registers and stale flag
  kuz_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .key_start_i (cmd.key_start),
    .key_o       (key),
    .stale_o     (stale)
  );

  // sequencer for key schedule and rounds
  kuz_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .stale_i (stale),
    .busy    (busy),
    .cmd_o   (cmd)
  );

  // round key store, state register and shared s/l unit
  kuz_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_i        (key),
    .command_i    (command_i),
    .block_high_i (block_high_i),
    .block_low_i  (block_low_i),
    .out_high_o   (out_high_o),
    .out_low_o    (out_low_o),
    .out_valid_o  (out_valid_o)
  );

endmodule

/* sv/kuz_regs.sv */
module kuz_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          key_start_i,
  output logic [255:0]  key_o,
  output logic          stale_o
);

  logic [63:0] key_q [4];
  logic        stale_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      stale_q <= 1'b1;
    end else begin
      if (wr) key_q[paddr[4:3]] <= pwdata;
      // a write wins over a schedule start in the same cycle
      if (wr) stale_q <= 1'b1;
      else if (key_start_i) stale_q <= 1'b0;
    end
  end

  assign prdata  = key_q[paddr[4:3]];
  assign key_o   = {key_q[0], key_q[1], key_q[2], key_q[3]};
  assign stale_o = stale_q;

endmodule

/* sv/kuz_dp.sv */
module kuz_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kuz_pkg::kuz_cmd_t  cmd_i,
  input  logic [255:0]       key_i,
  input  logic               command_i,
  input  logic [63:0]        block_high_i,
  input  logic [63:0]        block_low_i,
  output logic [63:0]        out_high_o,
  output logic [63:0]        out_low_o,
  output logic               out_valid_o
);

  kuz_pkg::blk_t rk_q [kuz_pkg::NumRoundKeys];
  kuz_pkg::blk_t s_q, a1_q, a0_q, out_q;
  logic          dec_q;
  logic          valid_q;
  logic [3:0]    kidx;
  kuz_pkg::blk_t rkey, mixed, fwd_in, fwd_out, inv_out, t_new;
  logic [3:0]    widx;

  assign kidx    = dec_q ? 4'(kuz_pkg::NumRoundKeys - 1) - cmd_i.cnt[3:0] : cmd_i.cnt[3:0];
  assign rkey    = rk_q[kidx];
  assign mixed   = s_q ^ rkey;
  assign fwd_in  = cmd_i.key_step ? (a1_q ^ kuz_pkg::KEY_CONST[cmd_i.cnt]) : mixed;
  // shared S then L unit, used by encrypt rounds and by the key schedule
  assign fwd_out = kuz_pkg::lin_apply(kuz_pkg::sub_bytes(fwd_in, kuz_pkg::SBOX),
                                      kuz_pkg::L_MAT);
  assign inv_out = kuz_pkg::sub_bytes(kuz_pkg::lin_apply(mixed, kuz_pkg::LINV_MAT),
                                      kuz_pkg::SBOX_INV);
  assign t_new   = fwd_out ^ a0_q;
  assign widx    = {cmd_i.cnt[4:3], 1'b0} + 4'd2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_start) begin
      a1_q     <= key_i[255:128];
      a0_q     <= key_i[127:0];
      rk_q[0]  <= key_i[255:128];
      rk_q[1]  <= key_i[127:0];
    end
    if (cmd_i.key_step) begin
      a1_q <= t_new;
      a0_q <= a1_q;
      if (cmd_i.cnt[2:0] == 3'd7) begin
        rk_q[widx]        <= t_new;
        rk_q[widx + 4'd1] <= a1_q;
      end
    end
    if (cmd_i.load) begin
      s_q   <= {block_high_i, block_low_i};
      dec_q <= command_i;
    end else if (cmd_i.round_step) begin
      s_q <= dec_q ? inv_out : fwd_out;
    end
    if (cmd_i.round_last) out_q <= mixed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= cmd_i.round_last;
  end

  assign out_high_o  = out_q[127:64];
  assign out_low_o   = out_q[63:0];
  assign out_valid_o = valid_q;

endmodule

/* sv/kuz_ctrl.sv */
module kuz_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               stale_i,
  output logic               busy,
  output kuz_pkg::kuz_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_KEYX = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  assign busy = (state_q != ST_IDLE) | stale_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.cnt = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (stale_i) begin
          cmd_o.key_start = 1'b1;
          state_d = ST_KEYX;
        end else if (start) begin
          cmd_o.load = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_KEYX: begin
        cmd_o.key_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(kuz_pkg::ScheduleSteps - 1)) state_d = ST_IDLE;
      end
      ST_RUN: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(kuz_pkg::NumRoundKeys - 1)) begin
          cmd_o.round_last = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.round_step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == 5'(kuz_pkg::NumRoundKeys - 1)) |=> state_q == ST_IDLE)
    else $error("round sequence did not end");
  a_run_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> cnt_q <= 5'(kuz_pkg::NumRoundKeys - 1))
    else $error("round counter overran");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == ST_RUN && cnt_q == 5'd0)
    else $error("accepted block did not start");
  a_keyx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && stale_i) |=> state_q == ST_KEYX)
    else $error("stale key did not start the schedule");

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 16;

  typedef enum logic {
    CmdEncrypt = 1'b0,
    CmdDecrypt = 1'b1
  } blk_cmd_e;

  typedef enum logic [4:0] {
    AddrKey0 = 5'd0,
    AddrKey1 = 5'd8,
    AddrKey2 = 5'd16,
    AddrKey3 = 5'd24
  } key_addr_e;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        out_valid_o;
  logic [63:0] out_high_o;
  logic [63:0] out_low_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  block_cipher_128_gost dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .block_high_i (block_high_i),
    .block_low_i  (block_low_i),
    .out_valid_o  (out_valid_o),
    .out_high_o   (out_high_o),
    .out_low_o    (out_low_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // model state: master key, expanded round keys, schedule constants
  logic [63:0]   key_words [4];
  kuz_pkg::blk_t round_keys [10];
  kuz_pkg::blk_t sched_const [32];
  logic [7:0]    sbox_rev [256];

  kuz_pkg::blk_t cipher_out_q [$];
  kuz_pkg::blk_t last_cipher;
  int unsigned   error_count;
  int unsigned   cycle_count;
  int unsigned   burst_left;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
    end
    return acc;
  endfunction

  // sixteen linear-feedback shifts, new byte enters at byte 0 (msb side)
  function automatic kuz_pkg::blk_t mix_fwd(input kuz_pkg::blk_t v);
    kuz_pkg::blk_t s;
    logic [7:0] acc;
    s = v;
    repeat (16) begin
      acc = '0;
      for (int i = 0; i < 16; i++) acc ^= gf_prod(kuz_pkg::LIN_COEF[i], s[127-8*i -: 8]);
      s = {acc, s[127:8]};
    end
    return s;
  endfunction

  function automatic kuz_pkg::blk_t mix_back(input kuz_pkg::blk_t v);
    kuz_pkg::blk_t s;
    logic [7:0] acc;
    s = v;
    repeat (16) begin
      acc = s[127:120];
      for (int i = 0; i < 15; i++) acc ^= gf_prod(kuz_pkg::LIN_COEF[i], s[119-8*i -: 8]);
      s = {s[119:0], acc};
    end
    return s;
  endfunction

  function automatic kuz_pkg::blk_t subst_fwd(input kuz_pkg::blk_t v);
    kuz_pkg::blk_t s;
    for (int i = 0; i < 16; i++) s[8*i +: 8] = kuz_pkg::SBOX[v[8*i +: 8]];
    return s;
  endfunction

  function automatic kuz_pkg::blk_t subst_back(input kuz_pkg::blk_t v);
    kuz_pkg::blk_t s;
    for (int i = 0; i < 16; i++) s[8*i +: 8] = sbox_rev[v[8*i +: 8]];
    return s;
  endfunction

  // feistel key schedule, a pair of round keys every eight steps
  function automatic void expand_round_keys();
    kuz_pkg::blk_t hi_half;
    kuz_pkg::blk_t lo_half;
    kuz_pkg::blk_t t;
    hi_half = {key_words[0], key_words[1]};
    lo_half = {key_words[2], key_words[3]};
    round_keys[0] = hi_half;
    round_keys[1] = lo_half;
    for (int step = 0; step < 32; step++) begin
      t = mix_fwd(subst_fwd(hi_half ^ sched_const[step])) ^ lo_half;
      lo_half = hi_half;
      hi_half = t;
      if (step % 8 == 7) begin
        round_keys[2*(step/8)+2] = hi_half;
        round_keys[2*(step/8)+3] = lo_half;
      end
    end
  endfunction

  function automatic kuz_pkg::blk_t cipher_block(input blk_cmd_e cmd, input kuz_pkg::blk_t v);
    kuz_pkg::blk_t s;
    s = v;
    if (cmd == CmdEncrypt) begin
      for (int r = 0; r < 9; r++) s = mix_fwd(subst_fwd(s ^ round_keys[r]));
      s ^= round_keys[9];
    end else begin
      s ^= round_keys[9];
      for (int r = 8; r >= 0; r--) s = subst_back(mix_back(s)) ^ round_keys[r];
    end
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one block transfer; caller sits just after a rising edge, start stays high on return
  task automatic send_block(input blk_cmd_e cmd, input logic [63:0] hi, input logic [63:0] lo);
    start        <= 1'b1;
    command_i    <= cmd;
    block_high_i <= hi;
    block_low_i  <= lo;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    last_cipher = cipher_block(cmd, {hi, lo});
    cipher_out_q.insert(cipher_out_q.size(), last_cipher);
  endtask

  task automatic pause_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // bursty sender: random burst lengths, random gaps, some long gap-free stretches
  task automatic send_paced(input blk_cmd_e cmd, input logic [63:0] hi, input logic [63:0] lo);
    send_block(cmd, hi, lo);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
      pause_sender($urandom_range(1, 14));
    end
  endtask

  // key writes only with nothing in flight
  task automatic wait_idle();
    pause_sender(0);
    while (cipher_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_key(input key_addr_e addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_words[addr / 8] = value;
    // read back
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== value) begin
      $display("%0t key readback at %0d: expected %h actual %h", $time, addr, value, prdata);
      error_count++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_key(input logic [255:0] k);
    wait_idle();
    write_key(AddrKey0, k[255:192]);
    write_key(AddrKey1, k[191:128]);
    write_key(AddrKey2, k[127:64]);
    write_key(AddrKey3, k[63:0]);
    expand_round_keys();
  endtask

  // reset key is all zero: field extremes, both commands
  task automatic test_reset_key();
    send_block(CmdEncrypt, '0, '0);
    send_block(CmdDecrypt, '0, '0);
    send_block(CmdEncrypt, '1, '1);
    send_block(CmdDecrypt, '1, '1);
    send_block(CmdEncrypt, 64'h8000_0000_0000_0000, 64'h1);
    pause_sender(3);
    send_block(CmdDecrypt, 64'h1, 64'h8000_0000_0000_0000);
    pause_sender(1);
  endtask

  // published example key and block, then the round trip
  task automatic test_standard_vector();
    load_key(256'h8899aabbccddeeff0011223344556677_fedcba98765432100123456789abcdef);
    send_block(CmdEncrypt, 64'h1122334455667700, 64'hffeeddccbbaa9988);
    send_block(CmdDecrypt, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd);
    send_block(CmdDecrypt, last_cipher[127:64], last_cipher[63:0]);
    pause_sender(1);
  endtask

  // all-ones key, then a single changed word to check re-expansion
  task automatic test_key_extremes();
    load_key('1);
    send_block(CmdEncrypt, '0, '1);
    send_block(CmdDecrypt, '1, '0);
    wait_idle();
    write_key(AddrKey2, 64'h0123_4567_89ab_cdef);
    expand_round_keys();
    send_block(CmdEncrypt, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_block(CmdDecrypt, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    pause_sender(1);
  endtask

  // random keys per phase; decrypts often undo the previous ciphertext
  task automatic test_random_traffic();
    blk_cmd_e cmd;
    burst_left = 0;
    for (int phase = 0; phase < 8; phase++) begin
      load_key({rand64(), rand64(), rand64(), rand64()});
      for (int n = 0; n < 117; n++) begin
        cmd = blk_cmd_e'($urandom_range(0, 1));
        if (cmd == CmdDecrypt && $urandom_range(0, 2) == 0)
          send_paced(cmd, last_cipher[127:64], last_cipher[63:0]);
        else
          send_paced(cmd, rand64(), rand64());
      end
    end
    pause_sender(0);
  endtask

  // result strobe is up one full cycle, so sample at the falling edge
  always @(negedge clk_i) begin
    kuz_pkg::blk_t want;
    if (rst_ni && out_valid_o === 1'b1) begin
      if (cipher_out_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h_%h",
                 $time, out_high_o, out_low_o);
        error_count++;
      end else begin
        want = cipher_out_q.pop_front();
        if (out_high_o !== want[127:64]) begin
          $display("%0t out_high: expected %h actual %h", $time, want[127:64], out_high_o);
          error_count++;
        end
        if (out_low_o !== want[63:0]) begin
          $display("%0t out_low: expected %h actual %h", $time, want[63:0], out_low_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("block_cipher_128_gost regression: fail");
      $finish;
    end
  end

  initial begin
    cycle_count  = 0;
    error_count  = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = 1'b0;
    block_high_i = '0;
    block_low_i  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    for (int i = 0; i < 256; i++) sbox_rev[kuz_pkg::SBOX[i]] = 8'(i);
    for (int i = 0; i < 32; i++) sched_const[i] = mix_fwd(kuz_pkg::blk_t'(i + 1));
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    expand_round_keys();
    last_cipher = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_standard_vector();
    test_key_extremes();
    test_random_traffic();

    while (cipher_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("block_cipher_128_gost regression: pass");
    end else begin
      $display("block_cipher_128_gost regression: fail");
    end
    $finish;
  end
endmodule
